[rtl/bellman_ford_shortest_paths_defines.svh]
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths: assertion macros
// Shared property wrappers for the assertions at the end of the datapath and controller.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BFSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/bfsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths: shared package
// Sizes, payload structs, controller/datapath interface and saturating add.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int MAX_VERTICES   = 16;
    localparam int MAX_EDGES      = 64;
    localparam int WEIGHT_BITS    = 16;
    localparam int DIST_BITS      = 24;

    localparam int VERT_BITS      = $clog2(MAX_VERTICES);
    localparam int NV_BITS        = VERT_BITS + 1;
    localparam int EDGE_IDX_BITS  = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_BITS  = EDGE_IDX_BITS + 1;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = NV_BITS;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_VERTICES  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_VERTEX = CFG_INDEX_BITS'(1);

    localparam logic [NV_BITS-1:0]   NV_RESET  = NV_BITS'(MAX_VERTICES);
    localparam logic [VERT_BITS-1:0] SRC_RESET = VERT_BITS'(0);

    typedef logic [VERT_BITS-1:0]          vertex_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [DIST_BITS-1:0]   dist_t;

    localparam dist_t DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam dist_t DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    typedef struct packed {
        vertex_t edge_src;
        vertex_t edge_dst;
        weight_t edge_weight;
        logic    last_edge;
    } in_item_t;

    typedef struct packed {
        vertex_t vertex;
        dist_t   distance;
        logic    reachable;
        logic    edges_dropped;
        logic    last_vertex;
    } out_item_t;

    // One stored edge.
    typedef struct packed {
        vertex_t src;
        vertex_t dst;
        weight_t weight;
    } edge_entry_t;

    localparam int EDGE_ENTRY_BITS = $bits(edge_entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                     load_en;
        logic                     init;
        logic                     relax;
        logic                     emit_sel;
        logic                     out_load;
        logic                     clear_graph;
        logic [EDGE_IDX_BITS-1:0] edge_idx;
        vertex_t                  round_idx;
        vertex_t                  vertex_idx;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_accepted;
        logic no_rounds;
        logic edge_last;
        logic round_last;
        logic vertex_last;
        logic out_free;
    } dp_status_t;

    // Distance plus weight, clamped to the distance range.
    function automatic dist_t sat_add(dist_t d, weight_t w);
        logic signed [DIST_BITS:0] s;
        s = (DIST_BITS+1)'(d) + (DIST_BITS+1)'(w);
        if (s[DIST_BITS] != s[DIST_BITS-1])
        begin
            return s[DIST_BITS] ? DIST_MIN : DIST_MAX;
        end
        return s[DIST_BITS-1:0];
    endfunction

endpackage

[rtl/bellman_ford_shortest_paths.sv]
`timescale 1ns / 1ps
// Loading: one edge transaction per cycle while idle; no result for ordinary edges.
// After the final edge: a start state, then edge read, distance read, sum and update per stored
// edge per round, for (num_vertices - 1) rounds through the single relaxation unit.
// Results: per vertex a distance table read, then the result register load, which waits under stall.
// Reset clears control state, reached flags and configuration (16 vertices, source 0);
// the edge table is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths: top level
// Streams in a directed weighted edge list and returns per-vertex distances.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bfsp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 edge_valid,
    output logic                                 edge_stall,
    input  bfsp_pkg::in_item_t                   edge_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output bfsp_pkg::out_item_t                  res_data
);

    import bfsp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Edges are taken only while the controller is waiting for a graph.
    assign edge_stall = !cmd.load_en;

    bfsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bfsp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .edge_valid (edge_valid),
        .edge_data  (edge_data),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

[rtl/bfsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bfsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the addressed entry into the output register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bfsp_datapath.sv]
`timescale 1ns / 1ps
`include "bellman_ford_shortest_paths_defines.svh"
// ----------------------------------------------------------------------------
// Bellman-Ford datapath
// Configuration, edge table, distance tables, reached flags, relaxation
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module bfsp_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bfsp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 edge_valid,
    input  bfsp_pkg::in_item_t                   edge_data,
    input  logic                                 res_stall,
    output logic                                 res_valid,
    output bfsp_pkg::out_item_t                  res_data,
    input  bfsp_pkg::ctrl_cmd_t                  cmd,
    output bfsp_pkg::dp_status_t                 sts
);

    import bfsp_pkg::*;

    logic [NV_BITS-1:0]       num_vertices_reg;
    vertex_t                  source_vertex_reg;
    logic [NV_BITS-1:0]       nv_eff;
    logic                     src_in_range;
    logic [EDGE_CNT_BITS-1:0] count_reg;
    logic                     overflow_reg;
    logic                     accept;
    logic                     store;
    logic [EDGE_ENTRY_BITS-1:0] edge_rdata;
    edge_entry_t              edge_q;
    edge_entry_t              edge_wdata;
    logic [MAX_VERTICES-1:0]  reached_reg;
    logic [DIST_BITS-1:0]     dist_a_rdata;
    logic [DIST_BITS-1:0]     dist_b_rdata;
    dist_t                    dist_a_q;
    dist_t                    dist_b_q;
    vertex_t                  dist_a_raddr;
    logic                     dist_we;
    vertex_t                  dist_waddr;
    dist_t                    dist_wdata;
    dist_t                    sum_reg;
    logic                     edge_in_range;
    logic                     relax_ok;
    logic                     res_valid_reg;
    out_item_t                res_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg  <= NV_RESET;
            source_vertex_reg <= SRC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_VERTICES:  num_vertices_reg  <= cfg_wdata;
                CFG_SOURCE_VERTEX: source_vertex_reg <= cfg_wdata[VERT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Vertex count in use: zero counts as one, large values clamp.
    always_comb
    begin
        if (num_vertices_reg == '0)
        begin
            nv_eff = NV_BITS'(1);
        end
        else if (num_vertices_reg > NV_BITS'(MAX_VERTICES))
        begin
            nv_eff = NV_BITS'(MAX_VERTICES);
        end
        else
        begin
            nv_eff = num_vertices_reg;
        end
    end

    assign src_in_range = NV_BITS'(source_vertex_reg) < nv_eff;

    // Edge loading: store while there is room, otherwise note the overflow.
    assign accept = edge_valid && cmd.load_en;
    assign store  = accept && (count_reg < EDGE_CNT_BITS'(MAX_EDGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.clear_graph)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (store)
            begin
                count_reg <= count_reg + EDGE_CNT_BITS'(1);
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    assign edge_wdata.src    = edge_data.edge_src;
    assign edge_wdata.dst    = edge_data.edge_dst;
    assign edge_wdata.weight = edge_data.edge_weight;

    bfsp_ram #(
        .WIDTH (EDGE_ENTRY_BITS),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[EDGE_IDX_BITS-1:0]),
        .wdata (edge_wdata),
        .raddr (cmd.edge_idx),
        .rdata (edge_rdata)
    );

    assign edge_q = edge_rdata;

    // Distance table, held twice so that source and destination read together.
    assign dist_a_raddr = cmd.emit_sel ? cmd.vertex_idx : edge_q.src;

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = edge_q.dst;
        dist_wdata = sum_reg;
        if (cmd.init)
        begin
            dist_we    = src_in_range;
            dist_waddr = source_vertex_reg;
            dist_wdata = '0;
        end
        else if (relax_ok)
        begin
            dist_we = 1'b1;
        end
    end

    bfsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_a_raddr),
        .rdata (dist_a_rdata)
    );

    bfsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (edge_q.dst),
        .rdata (dist_b_rdata)
    );

    assign dist_a_q = dist_a_rdata;
    assign dist_b_q = dist_b_rdata;

    // Candidate distance through the current edge, saturated.
    always_ff @(posedge clk)
    begin
        sum_reg <= sat_add(dist_a_q, edge_q.weight);
    end

    // Relaxation test: both ends in use, source reached, candidate improves or destination not yet reached.
    assign edge_in_range = (NV_BITS'(edge_q.src) < nv_eff) &&
                           (NV_BITS'(edge_q.dst) < nv_eff);
    assign relax_ok = cmd.relax && edge_in_range && reached_reg[edge_q.src] &&
                      (!reached_reg[edge_q.dst] || (sum_reg < dist_b_q));

    // Reached flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
        end
        else if (cmd.init)
        begin
            reached_reg <= '0;
            if (src_in_range)
            begin
                reached_reg[source_vertex_reg] <= 1'b1;
            end
        end
        else if (relax_ok)
        begin
            reached_reg[edge_q.dst] <= 1'b1;
        end
    end

    // Result register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg.vertex        <= cmd.vertex_idx;
            res_reg.distance      <= reached_reg[cmd.vertex_idx] ? dist_a_q : '0;
            res_reg.reachable     <= reached_reg[cmd.vertex_idx];
            res_reg.edges_dropped <= overflow_reg;
            res_reg.last_vertex   <= sts.vertex_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Status back to the controller.
    assign sts.last_accepted = accept && edge_data.last_edge;
    assign sts.no_rounds     = (nv_eff == NV_BITS'(1)) || (count_reg == '0);
    assign sts.edge_last     = (EDGE_CNT_BITS'(cmd.edge_idx) + EDGE_CNT_BITS'(1)) == count_reg;
    assign sts.round_last    = (NV_BITS'(cmd.round_idx) + NV_BITS'(1)) == nv_eff;
    assign sts.vertex_last   = (NV_BITS'(cmd.vertex_idx) + NV_BITS'(1)) == nv_eff;
    assign sts.out_free      = !res_valid_reg || !res_stall;

    // The edge count never passes the table size.
    `BFSP_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= EDGE_CNT_BITS'(MAX_EDGES), "edge count beyond table size")
    // A result is only loaded when the result register is free.
    `BFSP_ASSERT_IMPLIES(a_load_when_free, clk, rst_n, cmd.out_load, !res_valid_reg || !res_stall, "result overwritten before transaction")
    // After start-up of a run the source in use is marked reached.
    `BFSP_ASSERT_NEXT(a_source_reached, clk, rst_n, cmd.init && src_in_range, reached_reg[source_vertex_reg], "source vertex not reached after start")

endmodule

[rtl/bfsp_ctrl.sv]
`timescale 1ns / 1ps
`include "bellman_ford_shortest_paths_defines.svh"
// ----------------------------------------------------------------------------
// Bellman-Ford controller
// Sequences edge loading, the relaxation rounds and result emission.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfsp_pkg::dp_status_t  sts,
    output bfsp_pkg::ctrl_cmd_t   cmd
);

    import bfsp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_EDGE_RD,
        S_DIST_RD,
        S_CALC,
        S_UPDATE,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [EDGE_IDX_BITS-1:0] edge_idx_reg;
    logic [EDGE_IDX_BITS-1:0] edge_idx_next;
    vertex_t                  round_reg;
    vertex_t                  round_next;
    vertex_t                  vertex_reg;
    vertex_t                  vertex_next;

    // Next state, counters and commands.
    always_comb
    begin
        state_next    = state_reg;
        edge_idx_next = edge_idx_reg;
        round_next    = round_reg;
        vertex_next   = vertex_reg;

        cmd             = '0;
        cmd.edge_idx    = edge_idx_reg;
        cmd.round_idx   = round_reg;
        cmd.vertex_idx  = vertex_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_en = 1'b1;
                if (sts.last_accepted)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init      = 1'b1;
                edge_idx_next = '0;
                round_next    = VERT_BITS'(1);
                vertex_next   = '0;
                state_next    = sts.no_rounds ? S_EMIT_RD : S_EDGE_RD;
            end
            S_EDGE_RD:
            begin
                state_next = S_DIST_RD;
            end
            S_DIST_RD:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.relax = 1'b1;
                if (sts.edge_last)
                begin
                    edge_idx_next = '0;
                    if (sts.round_last)
                    begin
                        vertex_next = '0;
                        state_next  = S_EMIT_RD;
                    end
                    else
                    begin
                        round_next = round_reg + VERT_BITS'(1);
                        state_next = S_EDGE_RD;
                    end
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + EDGE_IDX_BITS'(1);
                    state_next    = S_EDGE_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_sel = 1'b1;
                state_next   = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                cmd.emit_sel = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.vertex_last)
                    begin
                        cmd.clear_graph = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        vertex_next = vertex_reg + VERT_BITS'(1);
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            edge_idx_reg <= '0;
            round_reg    <= '0;
            vertex_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            edge_idx_reg <= edge_idx_next;
            round_reg    <= round_next;
            vertex_reg   <= vertex_next;
        end
    end

    // A run starts only after the final edge transaction.
    `BFSP_ASSERT_IMPLIES(a_init_after_last, clk, rst_n, state_reg == S_INIT, $past(sts.last_accepted), "run started without a final edge")
    // The last edge of the last round hands over to emission from vertex zero.
    `BFSP_ASSERT_NEXT(a_sweep_to_emit, clk, rst_n, state_reg == S_UPDATE && sts.edge_last && sts.round_last, state_reg == S_EMIT_RD && vertex_reg == '0, "emission not started after final round")
    // Each delivered result other than the last moves on to the next vertex.
    `BFSP_ASSERT_NEXT(a_emit_step, clk, rst_n, state_reg == S_EMIT_OUT && sts.out_free && !sts.vertex_last, state_reg == S_EMIT_RD && vertex_reg == $past(vertex_reg) + VERT_BITS'(1), "vertex not advanced after result")

endmodule
